// File: src/assert_macros.svh
// Assertion macros shared by the frustum box cull RTL.
// Define NO_ASSERTIONS to compile them out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define FC_ASSERT_IMP(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define FC_ASSERT_NXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`else

`define FC_ASSERT_IMP(name, clk, rst, ante, cons, msg)
`define FC_ASSERT_NXT(name, clk, rst, ante, cons, msg)

`endif

`endif

// File: src/fcull_pkg.sv
// Shared types and constants for the frustum box cull block.
// No dependencies.
`timescale 1ns / 1ps

package fcull_pkg;

   localparam int PLANE_W = 3;

   localparam logic CMD_WRITE = 1'b0;
   localparam logic CMD_TEST  = 1'b1;

   typedef struct packed {
      logic               valid;
      logic [PLANE_W-1:0] plane;
   } fcull_issue_type;

   typedef struct packed {
      logic               valid;
      logic [PLANE_W-1:0] plane;
      logic               neg;
   } fcull_dot_status_type;

endpackage

// File: src/fcull_if.sv
// Request and response channel interfaces (valid/ready) for the cull core.
// Depends on fcull_pkg.
`timescale 1ns / 1ps

interface fcull_req_if import fcull_pkg::*; #(
   parameter int COORD_WIDTH  = 24,
   parameter int NORMAL_WIDTH = 16
);
   logic                           valid;
   logic                           ready;
   logic                           command;
   logic [PLANE_W-1:0]             plane_slot;
   logic signed [NORMAL_WIDTH-1:0] normal_x;
   logic signed [NORMAL_WIDTH-1:0] normal_y;
   logic signed [NORMAL_WIDTH-1:0] normal_z;
   logic signed [COORD_WIDTH-1:0]  plane_offset;
   logic signed [COORD_WIDTH-1:0]  box_min_x;
   logic signed [COORD_WIDTH-1:0]  box_min_y;
   logic signed [COORD_WIDTH-1:0]  box_min_z;
   logic signed [COORD_WIDTH-1:0]  box_max_x;
   logic signed [COORD_WIDTH-1:0]  box_max_y;
   logic signed [COORD_WIDTH-1:0]  box_max_z;

   modport source (
      output valid, command, plane_slot, normal_x, normal_y, normal_z, plane_offset,
             box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z,
      input  ready
   );
   modport sink (
      input  valid, command, plane_slot, normal_x, normal_y, normal_z, plane_offset,
             box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z,
      output ready
   );
endinterface

interface fcull_rsp_if import fcull_pkg::*;;
   logic               valid;
   logic               ready;
   logic               visible;
   logic [PLANE_W-1:0] culled_plane;

   modport source (output valid, visible, culled_plane, input ready);
   modport sink   (input valid, visible, culled_plane, output ready);
endinterface

// File: src/fcull_plane_store.sv
// Plane store: normals and offsets in flops, cleared at reset, one write port
// and one combinational read port. Depends on fcull_pkg.
`timescale 1ns / 1ps

module fcull_plane_store import fcull_pkg::*; #(
   parameter int NUM_PLANES   = 6,
   parameter int COORD_WIDTH  = 24,
   parameter int NORMAL_WIDTH = 16,
   localparam int IDX_W       = (NUM_PLANES > 1) ? $clog2(NUM_PLANES) : 1
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           wr_en,
   input  logic [PLANE_W-1:0]             wr_slot,
   input  logic signed [NORMAL_WIDTH-1:0] wr_normal [3],
   input  logic signed [COORD_WIDTH-1:0]  wr_offset,
   input  logic [IDX_W-1:0]               rd_index,
   output logic signed [NORMAL_WIDTH-1:0] rd_normal [3],
   output logic signed [COORD_WIDTH-1:0]  rd_offset
);

   logic signed [NORMAL_WIDTH-1:0] normal_ff [NUM_PLANES][3];
   logic signed [COORD_WIDTH-1:0]  offset_ff [NUM_PLANES];
   logic                           wr_hit;

   // slots past the plane count are dropped
   assign wr_hit = wr_en && ({1'b0, wr_slot} < (PLANE_W + 1)'(NUM_PLANES));

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int p = 0; p < NUM_PLANES; p++) begin
            for (int a = 0; a < 3; a++) begin
               normal_ff[p][a] <= '0;
            end
            offset_ff[p] <= '0;
         end
      end else if (wr_hit) begin
         for (int a = 0; a < 3; a++) begin
            normal_ff[wr_slot[IDX_W-1:0]][a] <= wr_normal[a];
         end
         offset_ff[wr_slot[IDX_W-1:0]] <= wr_offset;
      end
   end

   always_comb begin
      for (int a = 0; a < 3; a++) begin
         rd_normal[a] = normal_ff[rd_index][a];
      end
      rd_offset = offset_ff[rd_index];
   end

endmodule

// File: src/fcull_dot_unit.sv
// Shared plane test unit: p-vertex select, three products (stage A),
// exact sum with scaled offset and sign (stage B). Depends on fcull_pkg.
`timescale 1ns / 1ps

module fcull_dot_unit import fcull_pkg::*; #(
   parameter int COORD_WIDTH  = 24,
   parameter int NORMAL_WIDTH = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   input  fcull_issue_type                issue,
   input  logic signed [NORMAL_WIDTH-1:0] normal [3],
   input  logic signed [COORD_WIDTH-1:0]  offset,
   input  logic signed [COORD_WIDTH-1:0]  box_min [3],
   input  logic signed [COORD_WIDTH-1:0]  box_max [3],
   output fcull_dot_status_type           status
);

   localparam int PROD_W = NORMAL_WIDTH + COORD_WIDTH;
   localparam int ACC_W  = PROD_W + 2;
   localparam int SHIFT  = NORMAL_WIDTH - 2;   // d moves from Q.8 to Q.22

   logic signed [COORD_WIDTH-1:0] corner  [3];
   logic signed [PROD_W-1:0]      prod_in [3];
   logic signed [PROD_W-1:0]      prod_ff [3];
   logic signed [COORD_WIDTH-1:0] off_ff;
   fcull_issue_type               stage_a_ff;
   logic signed [ACC_W-1:0]       sum;
   fcull_dot_status_type          status_in;
   fcull_dot_status_type          status_ff;

   always_comb begin
      for (int a = 0; a < 3; a++) begin
         // negative normal component picks the min corner
         corner[a]  = normal[a][NORMAL_WIDTH-1] ? box_min[a] : box_max[a];
         prod_in[a] = normal[a] * corner[a];
      end
   end

   always_ff @(posedge clock) begin
      for (int a = 0; a < 3; a++) begin
         prod_ff[a] <= prod_in[a];
      end
      off_ff <= offset;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_a_ff <= '0;
      end else begin
         stage_a_ff <= issue;
      end
   end

   assign sum = ACC_W'(prod_ff[0]) + ACC_W'(prod_ff[1]) + ACC_W'(prod_ff[2])
              + (ACC_W'(off_ff) <<< SHIFT);

   always_comb begin
      status_in.valid = stage_a_ff.valid;
      status_in.plane = stage_a_ff.plane;
      status_in.neg   = sum[ACC_W-1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         status_ff <= '0;
      end else begin
         status_ff <= status_in;
      end
   end

   assign status = status_ff;

endmodule

// File: src/frustum_box_cull_core.sv
// Frustum box cull core: p-vertex test of an axis-aligned box against stored planes.
// Plane write: taken while idle, no response. Box test: one issue per plane, then the
// dot-unit result, the finish state (held while an earlier response stalls) and the
// response flop; the next request is taken once the response is posted, not before.
// Synchronous active-high reset clears the plane store (all planes pass) and control.
// Depends on fcull_pkg, fcull_if, assert_macros.svh, store, dot unit.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module frustum_box_cull_core import fcull_pkg::*; #(
   parameter int NUM_PLANES   = 6,
   parameter int COORD_WIDTH  = 24,
   parameter int NORMAL_WIDTH = 16
) (
   input logic         clock,
   input logic         reset,
   fcull_req_if.sink   req_if,
   fcull_rsp_if.source rsp_if
);

   localparam int IDX_W = (NUM_PLANES > 1) ? $clog2(NUM_PLANES) : 1;
   localparam int CNT_W = $clog2(NUM_PLANES + 1);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_RUN  = 2'd1;
   localparam logic [1:0] ST_FIN  = 2'd2;

   localparam logic [PLANE_W-1:0] LAST_PLANE = PLANE_W'(NUM_PLANES - 1);
   localparam logic [PLANE_W-1:0] NONE_CODE  = PLANE_W'(NUM_PLANES);

   logic [1:0]                    state_ff, state_in;
   logic [CNT_W-1:0]              issue_ff, issue_in;
   logic                          found_ff, found_in;
   logic [PLANE_W-1:0]            fail_ff, fail_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic                          rsp_visible_ff, rsp_visible_in;
   logic [PLANE_W-1:0]            rsp_culled_ff, rsp_culled_in;
   logic signed [COORD_WIDTH-1:0] box_min_ff [3];
   logic signed [COORD_WIDTH-1:0] box_max_ff [3];

   logic                           accept;
   logic                           rsp_free;
   logic signed [NORMAL_WIDTH-1:0] wr_normal [3];
   logic signed [NORMAL_WIDTH-1:0] rd_normal [3];
   logic signed [COORD_WIDTH-1:0]  rd_offset;
   fcull_issue_type                issue;
   fcull_dot_status_type           dot_status;

   assign req_if.ready = (state_ff == ST_IDLE);
   assign accept       = req_if.valid && req_if.ready;
   assign rsp_free     = !rsp_valid_ff || rsp_if.ready;

   assign wr_normal[0] = req_if.normal_x;
   assign wr_normal[1] = req_if.normal_y;
   assign wr_normal[2] = req_if.normal_z;

   fcull_plane_store #(
      .NUM_PLANES  (NUM_PLANES),
      .COORD_WIDTH (COORD_WIDTH),
      .NORMAL_WIDTH(NORMAL_WIDTH)
   ) u_store (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (accept && (req_if.command == CMD_WRITE)),
      .wr_slot  (req_if.plane_slot),
      .wr_normal(wr_normal),
      .wr_offset(req_if.plane_offset),
      .rd_index (issue_ff[IDX_W-1:0]),
      .rd_normal(rd_normal),
      .rd_offset(rd_offset)
   );

   always_comb begin
      issue.valid = (state_ff == ST_RUN) && (issue_ff < CNT_W'(NUM_PLANES));
      issue.plane = PLANE_W'(issue_ff);
   end

   fcull_dot_unit #(
      .COORD_WIDTH (COORD_WIDTH),
      .NORMAL_WIDTH(NORMAL_WIDTH)
   ) u_dot (
      .clock  (clock),
      .reset  (reset),
      .issue  (issue),
      .normal (rd_normal),
      .offset (rd_offset),
      .box_min(box_min_ff),
      .box_max(box_max_ff),
      .status (dot_status)
   );

   // box corners held for the whole test
   always_ff @(posedge clock) begin
      if (accept && (req_if.command == CMD_TEST)) begin
         box_min_ff[0] <= req_if.box_min_x;
         box_min_ff[1] <= req_if.box_min_y;
         box_min_ff[2] <= req_if.box_min_z;
         box_max_ff[0] <= req_if.box_max_x;
         box_max_ff[1] <= req_if.box_max_y;
         box_max_ff[2] <= req_if.box_max_z;
      end
   end

   always_comb begin
      state_in       = state_ff;
      issue_in       = issue_ff;
      found_in       = found_ff;
      fail_in        = fail_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_if.ready;
      rsp_visible_in = rsp_visible_ff;
      rsp_culled_in  = rsp_culled_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && (req_if.command == CMD_TEST)) begin
               state_in = ST_RUN;
               issue_in = '0;
               found_in = 1'b0;
               fail_in  = NONE_CODE;
            end
         end
         ST_RUN: begin
            if (issue.valid) begin
               issue_in = issue_ff + 1'b1;
            end
            if (dot_status.valid) begin
               // keep only the first failing plane
               if (dot_status.neg && !found_ff) begin
                  found_in = 1'b1;
                  fail_in  = dot_status.plane;
               end
               if (dot_status.plane == LAST_PLANE) begin
                  state_in = ST_FIN;
               end
            end
         end
         ST_FIN: begin
            if (rsp_free) begin
               rsp_valid_in   = 1'b1;
               rsp_visible_in = !found_ff;
               rsp_culled_in  = fail_ff;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         issue_ff     <= '0;
         found_ff     <= 1'b0;
         fail_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         issue_ff     <= issue_in;
         found_ff     <= found_in;
         fail_ff      <= fail_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_visible_ff <= rsp_visible_in;
      rsp_culled_ff  <= rsp_culled_in;
   end

   assign rsp_if.valid        = rsp_valid_ff;
   assign rsp_if.visible      = rsp_visible_ff;
   assign rsp_if.culled_plane = rsp_culled_ff;

   `FC_ASSERT_IMP(a_status_in_run, clock, reset, dot_status.valid, state_ff == ST_RUN, "dot result outside a box test")
   `FC_ASSERT_NXT(a_test_starts, clock, reset, accept && (req_if.command == CMD_TEST), state_ff == ST_RUN, "box test did not start")
   `FC_ASSERT_IMP(a_rsp_from_fin, clock, reset, $rose(rsp_valid_ff), $past(state_ff) == ST_FIN, "response posted outside finish")
   `FC_ASSERT_IMP(a_visible_code, clock, reset, rsp_valid_ff && rsp_visible_ff, rsp_culled_ff == NONE_CODE, "visible box carries a plane index")

endmodule
